// File: rtl/core/assert_macros.svh
// assertion macros shared by the converter's queue and back part
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// File: rtl/core/ycc420_pkg.sv
// shared widths, constants and the command word type of the tile converter
package ycc420_pkg;

  localparam int unsigned COMP_W   = 8;
  localparam int unsigned SAMPLE_W = 9;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned YIDX_W   = 8;
  localparam int unsigned CIDX_W   = 6;
  localparam int unsigned PAIR_W   = 9;
  localparam int unsigned GROUPS   = 8;
  localparam int unsigned GCOL_W   = 3;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [INDEX_W-1:0]  CO_BASE       = 10'd256;
  localparam logic [INDEX_W-1:0]  CG_BASE       = 10'd320;
  localparam logic [INDEX_W-1:0]  ALPHA_BASE    = 10'd384;
  localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS   = 9'd128;
  localparam logic [SAMPLE_W-1:0] CHROMA_BIAS   = 9'd256;
  localparam logic [10:0]         CHROMA_OFFSET = 11'd1026;
  localparam logic [9:0]          LUMA_ROUND    = 10'd2;

  // one classified pixel: everything the back part needs to emit its words
  typedef struct packed {
    logic [YIDX_W-1:0]   yidx;
    logic [SAMPLE_W-1:0] luma;
    logic                has_chroma;
    logic [CIDX_W-1:0]   cidx;
    logic [SAMPLE_W-1:0] co;
    logic [SAMPLE_W-1:0] cg;
    logic                has_alpha;
    logic [SAMPLE_W-1:0] alpha;
  } ycc_cmd_t;

endpackage

// File: rtl/core/ycc420_pixel_if.sv
// valid/ready channel carrying one rgba pixel word
interface ycc420_pixel_if;
  import ycc420_pkg::*;

  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;
  logic [COMP_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

// File: rtl/core/ycc420_result_if.sv
// valid/ready channel carrying one planar sample word
interface ycc420_result_if;
  import ycc420_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [INDEX_W-1:0]         plane_index;
  logic signed [SAMPLE_W-1:0] value;
  logic                       last_of_run;

  modport source (output valid, output plane_index, output value, output last_of_run,
                  input ready);
  modport sink   (input valid, input plane_index, input value, input last_of_run,
                  output ready);
endinterface

// File: rtl/core/ycc420_front.sv
// front part: accepts pixels, tracks tile position, computes luma, chroma and alpha
module ycc420_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  ycc420_pixel_if.sink        pixels,
  input  logic                queue_full,
  output logic                cmd_push,
  output ycc420_pkg::ycc_cmd_t cmd
);
  import ycc420_pkg::*;

  typedef struct packed {
    logic [PAIR_W-1:0] r;
    logic [PAIR_W-1:0] g;
    logic [PAIR_W-1:0] b;
  } pair_sum_t;

  logic              alpha_en;
  logic [POS_W-1:0]  pos;
  logic [COMP_W-1:0] prev_r;
  logic [COMP_W-1:0] prev_g;
  logic [COMP_W-1:0] prev_b;
  pair_sum_t         pair_mem [GROUPS];

  logic              accept;
  logic [3:0]        row;
  logic [3:0]        col;
  logic [GCOL_W-1:0] gcol;
  logic [9:0]        luma_sum;
  pair_sum_t         pair_now;
  pair_sum_t         pair_old;
  logic [9:0]        tot_r;
  logic [9:0]        tot_g;
  logic [9:0]        tot_b;
  logic [7:0]        avg_r;
  logic [7:0]        avg_g;
  logic [7:0]        avg_b;
  logic [10:0]       co_t;
  logic [10:0]       cg_t;

  // handshake: take a pixel whenever the queue has room
  assign pixels.ready = !queue_full;
  assign accept       = pixels.valid && !queue_full;
  assign cmd_push     = accept;

  // position within the tile
  assign row  = pos[7:4];
  assign col  = pos[3:0];
  assign gcol = col[3:1];

  // luma with rounding, then bias removed
  assign luma_sum = {2'b00, pixels.red} + {1'b0, pixels.green, 1'b0}
                  + {2'b00, pixels.blue} + LUMA_ROUND;

  // horizontal pair sums and the 2x2 group average
  assign pair_now.r = {1'b0, prev_r} + {1'b0, pixels.red};
  assign pair_now.g = {1'b0, prev_g} + {1'b0, pixels.green};
  assign pair_now.b = {1'b0, prev_b} + {1'b0, pixels.blue};
  assign pair_old   = pair_mem[gcol];
  assign tot_r = {1'b0, pair_now.r} + {1'b0, pair_old.r};
  assign tot_g = {1'b0, pair_now.g} + {1'b0, pair_old.g};
  assign tot_b = {1'b0, pair_now.b} + {1'b0, pair_old.b};
  assign avg_r = tot_r[9:2];
  assign avg_g = tot_g[9:2];
  assign avg_b = tot_b[9:2];

  // chroma on a biased non-negative value so the shift floors
  assign co_t = {2'b00, avg_r, 1'b0} + CHROMA_OFFSET - {2'b00, avg_b, 1'b0};
  assign cg_t = {2'b00, avg_g, 1'b0} + CHROMA_OFFSET - {3'b000, avg_r} - {3'b000, avg_b};

  // command word for the queue
  always_comb begin
    cmd.yidx       = {row[3], col[3], row[2:0], col[2:0]};
    cmd.luma       = {1'b0, luma_sum[9:2]} - SAMPLE_BIAS;
    cmd.has_chroma = col[0] && row[0];
    cmd.cidx       = {row[3:1], col[3:1]};
    cmd.co         = co_t[10:2] - CHROMA_BIAS;
    cmd.cg         = cg_t[10:2] - CHROMA_BIAS;
    cmd.has_alpha  = alpha_en;
    cmd.alpha      = {1'b0, pixels.alpha} - SAMPLE_BIAS;
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_en <= 1'b1;
      pos      <= '0;
      prev_r   <= '0;
      prev_g   <= '0;
      prev_b   <= '0;
    end else begin
      if (cfg_we) begin
        alpha_en <= cfg_wdata;
      end
      if (accept) begin
        pos    <= pos + POS_W'(1);
        prev_r <= pixels.red;
        prev_g <= pixels.green;
        prev_b <= pixels.blue;
      end
    end
  end

  // even-row pair sums, kept until the odd row of the group arrives
  always_ff @(posedge clk) begin
    if (accept && col[0] && !row[0]) begin
      pair_mem[gcol] <= pair_now;
    end
  end

endmodule

// File: rtl/core/ycc420_queue.sv
// short command queue between the front and back parts
module ycc420_queue #(
  parameter int unsigned DEPTH = ycc420_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ycc420_pkg::ycc_cmd_t push_data,
  output logic                 full,
  input  logic                 pop,
  output ycc420_pkg::ycc_cmd_t head,
  output logic                 empty
);
  import ycc420_pkg::*;
`include "assert_macros.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ycc_cmd_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty, "queue popped while empty")
  `ASSERT_NEVER(a_count_bound, clk, rst, count > CNT_W'(DEPTH), "queue level beyond depth")

endmodule

// File: rtl/core/ycc420_back.sv
// back part: expands each command into its sample words on the result channel
module ycc420_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ycc420_pkg::ycc_cmd_t cmd,
  input  logic                 queue_empty,
  output logic                 cmd_pop,
  ycc420_result_if.source      results
);
  import ycc420_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [3:0] {
    KIND_LUMA  = 4'b0001,
    KIND_CO    = 4'b0010,
    KIND_CG    = 4'b0100,
    KIND_ALPHA = 4'b1000
  } kind_t;

  ycc_cmd_t                   cur;
  logic                       cur_valid;
  logic [1:0]                 seq;
  logic                       out_valid;
  logic [INDEX_W-1:0]         out_index;
  logic signed [SAMPLE_W-1:0] out_value;
  logic                       out_last;

  logic                       out_free;
  logic                       advance;
  logic [1:0]                 last_seq;
  logic                       is_last;
  kind_t                      kind;
  logic [INDEX_W-1:0]         index_next;
  logic [SAMPLE_W-1:0]        value_next;

  assign out_free = !out_valid || results.ready;
  assign advance  = cur_valid && out_free;
  assign last_seq = {cur.has_chroma, 1'b0} + {1'b0, cur.has_alpha};
  assign is_last  = (seq == last_seq);
  assign cmd_pop  = !queue_empty && (!cur_valid || (advance && is_last));

  // which word of the current pixel goes out next
  always_comb begin
    case (seq)
      2'd0:    kind = KIND_LUMA;
      2'd1:    kind = cur.has_chroma ? KIND_CO : KIND_ALPHA;
      2'd2:    kind = KIND_CG;
      default: kind = KIND_ALPHA;
    endcase
  end

  // word position and value for that kind
  always_comb begin
    case (kind)
      KIND_LUMA: begin
        index_next = {2'b00, cur.yidx};
        value_next = cur.luma;
      end
      KIND_CO: begin
        index_next = CO_BASE + {4'b0000, cur.cidx};
        value_next = cur.co;
      end
      KIND_CG: begin
        index_next = CG_BASE + {4'b0000, cur.cidx};
        value_next = cur.cg;
      end
      KIND_ALPHA: begin
        index_next = ALPHA_BASE + {2'b00, cur.yidx};
        value_next = cur.alpha;
      end
      default: begin
        index_next = '0;
        value_next = '0;
      end
    endcase
  end

  // control: current command, word counter, output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      seq       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        seq       <= is_last ? 2'd0 : seq + 2'd1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_pop) begin
        cur_valid <= 1'b1;
      end else if (advance && is_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (advance) begin
      out_index <= index_next;
      out_value <= value_next;
      out_last  <= is_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.plane_index = out_index;
  assign results.value       = out_value;
  assign results.last_of_run = out_last;

  `ASSERT_NEVER(a_seq_bound, clk, rst, cur_valid && (seq > last_seq), "word counter past pixel")
  `ASSERT_AT(a_seq_wrap, clk, rst, advance && is_last |=> seq == 2'd0, "counter not rewound")

endmodule

// File: rtl/core/rgb_tile_to_ycocg_420.sv
// top level of the rgb tile to ycocg 4:2:0 converter
//
//  channel   dir  handshake          word
//  pixels    in   valid/ready        red, green, blue, alpha (8 bit each)
//  results   out  valid/ready        plane_index (10), value (9 signed), last_of_run
//  cfg       in   cfg_we, no stall   cfg_wdata = alpha_enabled
//
// one result word per cycle leaves the back part's output register while the result
// channel is ready; a pixel has 1 to 4 words (2.5 on average with alpha on)
// a pixel is accepted every cycle while the command queue (QUEUE_DEPTH) has room
// rst is synchronous: tile position and previous pixel clear, alpha_enabled sets
// a stalled result channel backs up into the queue, then holds pixels.ready low
module rgb_tile_to_ycocg_420 #(
  parameter int unsigned QUEUE_DEPTH = ycc420_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  ycc420_pixel_if.sink     pixels,
  ycc420_result_if.source  results
);
  import ycc420_pkg::*;

  ycc_cmd_t cmd_in;
  ycc_cmd_t cmd_head;
  logic     cmd_push;
  logic     cmd_pop;
  logic     queue_full;
  logic     queue_empty;

  // classify pixels
  ycc420_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pixels     (pixels),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // decouple front and back
  ycc420_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (queue_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (queue_empty)
  );

  // emit sample words
  ycc420_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_head),
    .queue_empty (queue_empty),
    .cmd_pop     (cmd_pop),
    .results     (results)
  );

endmodule
